// File: rtl/tcsa_pkg.sv
`default_nettype none

package tcsa_pkg;

  localparam int unsigned AVG_BITS   = 12;
  localparam int unsigned SUM_BITS   = 16;
  localparam int unsigned ROUND_BITS = 5;
  localparam int unsigned SHIFT_BITS = 3;

  // largest shift that keeps the sums inside SUM_BITS
  localparam logic [SHIFT_BITS-1:0] MAX_SHIFT = 3'd4;
  localparam logic [SHIFT_BITS-1:0] RESET_SHIFT = 3'd3;

  typedef enum logic [1:0] {
    CH_POSITION = 2'd0,
    CH_CURRENT  = 2'd1,
    CH_VOLTAGE  = 2'd2
  } chan_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef struct packed {
    logic [1:0]          next_channel;
    logic                got;
    logic [AVG_BITS-1:0] position_avg;
    logic [AVG_BITS-1:0] current_avg;
    logic [AVG_BITS-1:0] voltage_avg;
    logic                is_ready;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/tcsa_core.sv
`default_nettype none

module tcsa_core #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write_en,
  input  wire logic [tcsa_pkg::SHIFT_BITS-1:0]    cfg_write_data,
  input  wire logic                               step,
  input  wire logic                               operation,
  input  wire logic [tcsa_pkg::AVG_BITS-1:0]      sample,
  output tcsa_pkg::res_t                          result
);

  localparam logic [tcsa_pkg::AVG_BITS-1:0] SAMPLE_MASK =
    tcsa_pkg::AVG_BITS'((1 << SAMPLE_BITS) - 1);

  logic [tcsa_pkg::SHIFT_BITS-1:0] acc_shift;
  tcsa_pkg::chan_t                 channel_sel, channel_sel_next;
  logic [tcsa_pkg::SUM_BITS-1:0]   position_sum, position_sum_next;
  logic [tcsa_pkg::SUM_BITS-1:0]   current_sum, current_sum_next;
  logic [tcsa_pkg::SUM_BITS-1:0]   voltage_sum, voltage_sum_next;
  logic [tcsa_pkg::ROUND_BITS-1:0] round_count, round_count_next;
  logic                            ready_flag, ready_flag_next;

  logic [tcsa_pkg::SHIFT_BITS-1:0] eff_shift;
  logic [tcsa_pkg::SUM_BITS-1:0]   smp_ext;
  logic [tcsa_pkg::ROUND_BITS-1:0] round_inc;
  logic [tcsa_pkg::ROUND_BITS-1:0] round_target;
  logic [tcsa_pkg::SUM_BITS-1:0]   pos_shifted, cur_shifted, volt_shifted;

  assign eff_shift = (acc_shift > tcsa_pkg::MAX_SHIFT) ? tcsa_pkg::MAX_SHIFT : acc_shift;
  assign smp_ext   = {{(tcsa_pkg::SUM_BITS - tcsa_pkg::AVG_BITS){1'b0}}, sample & SAMPLE_MASK};
  assign round_inc = round_count + 1'b1;
  assign round_target = tcsa_pkg::ROUND_BITS'(1) << eff_shift;

  assign pos_shifted  = position_sum >> eff_shift;
  assign cur_shifted  = current_sum >> eff_shift;
  assign volt_shifted = voltage_sum >> eff_shift;

  always_comb begin
    channel_sel_next  = channel_sel;
    position_sum_next = position_sum;
    current_sum_next  = current_sum;
    voltage_sum_next  = voltage_sum;
    round_count_next  = round_count;
    ready_flag_next   = ready_flag;
    result = '0;

    if (operation == tcsa_pkg::OP_SAMPLE) begin
      // samples are dropped while averages wait to be read
      if (!ready_flag) begin
        case (channel_sel)
          tcsa_pkg::CH_POSITION: begin
            position_sum_next = position_sum + smp_ext;
            channel_sel_next  = tcsa_pkg::CH_CURRENT;
          end
          tcsa_pkg::CH_CURRENT: begin
            current_sum_next = current_sum + smp_ext;
            channel_sel_next = tcsa_pkg::CH_VOLTAGE;
          end
          tcsa_pkg::CH_VOLTAGE: begin
            voltage_sum_next = voltage_sum + smp_ext;
            channel_sel_next = tcsa_pkg::CH_POSITION;
            if (round_inc >= round_target) begin
              round_count_next = '0;
              ready_flag_next  = 1'b1;
            end else begin
              round_count_next = round_inc;
            end
          end
          default: begin
            channel_sel_next = tcsa_pkg::CH_POSITION;
          end
        endcase
      end
    end else if (ready_flag) begin
      result.got          = 1'b1;
      result.position_avg = pos_shifted[tcsa_pkg::AVG_BITS-1:0];
      result.current_avg  = cur_shifted[tcsa_pkg::AVG_BITS-1:0];
      result.voltage_avg  = volt_shifted[tcsa_pkg::AVG_BITS-1:0];
      position_sum_next   = '0;
      current_sum_next    = '0;
      voltage_sum_next    = '0;
      ready_flag_next     = 1'b0;
    end

    result.next_channel = channel_sel_next;
    result.is_ready     = ready_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_shift    <= tcsa_pkg::RESET_SHIFT;
      channel_sel  <= tcsa_pkg::CH_POSITION;
      position_sum <= '0;
      current_sum  <= '0;
      voltage_sum  <= '0;
      round_count  <= '0;
      ready_flag   <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        acc_shift <= cfg_write_data;
      end
      if (step) begin
        channel_sel  <= channel_sel_next;
        position_sum <= position_sum_next;
        current_sum  <= current_sum_next;
        voltage_sum  <= voltage_sum_next;
        round_count  <= round_count_next;
        ready_flag   <= ready_flag_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/three_channel_scan_averager_unit.sv
// channel  | signals                                          | direction
// ---------+--------------------------------------------------+----------
// in       | in_valid, in_ready, operation, sample            | input beat
// out      | out_valid, out_ready, next_channel, got,         | output beat
//          | position_avg, current_avg, voltage_avg, is_ready |
// cfg      | cfg_write_en, cfg_write_data (acc_shift)         | write only
//
// one beat per cycle sustained while out_ready is high; a result is offered once its input
// beat has passed the input register, then the accumulate logic into the result register
// reset clears the sums, round counter, selector, ready flag and both valid bits;
// acc_shift returns to 3
// with out_ready low the result register holds, the input register takes one
// more beat, then in_ready drops until the result is taken
`default_nettype none

module three_channel_scan_averager_unit #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [11:0] sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       next_channel,
  output logic             got,
  output logic [11:0]      position_avg,
  output logic [11:0]      current_avg,
  output logic [11:0]      voltage_avg,
  output logic             is_ready,
  input  wire logic        cfg_write_en,
  input  wire logic [2:0]  cfg_write_data
);

  logic                              in_reg_valid;
  logic                              in_op;
  logic [tcsa_pkg::AVG_BITS-1:0]     in_sample;
  logic                              advance;
  tcsa_pkg::res_t                    core_result;
  tcsa_pkg::res_t                    out_reg;

  assign advance  = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || advance;

  tcsa_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .step          (advance),
    .operation     (in_op),
    .sample        (in_sample),
    .result        (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_reg_valid <= 1'b1;
      end else if (advance) begin
        in_reg_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_op     <= operation;
      in_sample <= sample;
    end
    if (advance) begin
      out_reg <= core_result;
    end
  end

  assign next_channel = out_reg.next_channel;
  assign got          = out_reg.got;
  assign position_avg = out_reg.position_avg;
  assign current_avg  = out_reg.current_avg;
  assign voltage_avg  = out_reg.voltage_avg;
  assign is_ready     = out_reg.is_ready;

endmodule

`default_nettype wire

// File: sim/scan_averager_checker.sv
`timescale 1ns / 100ps

module scan_averager_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        operation,
  input  wire logic [11:0] sample,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  next_channel,
  input  wire logic        got,
  input  wire logic [11:0] position_avg,
  input  wire logic [11:0] current_avg,
  input  wire logic [11:0] voltage_avg,
  input  wire logic        is_ready,
  input  wire logic        cfg_write_en,
  input  wire logic [2:0]  cfg_write_data,
  output int               fail_count,
  output int               due_count
);

  // shadow copy of the scan state
  logic [tcsa_pkg::SHIFT_BITS-1:0] shift_cfg;
  logic [1:0]                      sel;
  logic [tcsa_pkg::SUM_BITS-1:0]   pos_sum;
  logic [tcsa_pkg::SUM_BITS-1:0]   cur_sum;
  logic [tcsa_pkg::SUM_BITS-1:0]   volt_sum;
  logic [tcsa_pkg::ROUND_BITS-1:0] rounds;
  logic                            avg_ready;

  tcsa_pkg::res_t scan_results_due[$];
  int             err_count = 0;

  function automatic tcsa_pkg::res_t scan_step(tcsa_pkg::op_t op, logic [11:0] smp);
    tcsa_pkg::res_t r;
    int             sh;
    sh = (shift_cfg > tcsa_pkg::MAX_SHIFT) ? int'(tcsa_pkg::MAX_SHIFT) : int'(shift_cfg);
    r = '0;
    if (op == tcsa_pkg::OP_SAMPLE) begin
      // samples are dropped while averages wait for a read
      if (!avg_ready) begin
        case (sel)
          tcsa_pkg::CH_POSITION: begin
            pos_sum = pos_sum + tcsa_pkg::SUM_BITS'(smp);
            sel = tcsa_pkg::CH_CURRENT;
          end
          tcsa_pkg::CH_CURRENT: begin
            cur_sum = cur_sum + tcsa_pkg::SUM_BITS'(smp);
            sel = tcsa_pkg::CH_VOLTAGE;
          end
          tcsa_pkg::CH_VOLTAGE: begin
            volt_sum = volt_sum + tcsa_pkg::SUM_BITS'(smp);
            sel = tcsa_pkg::CH_POSITION;
            rounds = rounds + 1'b1;
            // >= so a shift lowered mid-run still completes
            if (int'(rounds) >= (1 << sh)) begin
              rounds = '0;
              avg_ready = 1'b1;
            end
          end
          default: sel = tcsa_pkg::CH_POSITION;
        endcase
      end
    end else if (avg_ready) begin
      r.got = 1'b1;
      r.position_avg = tcsa_pkg::AVG_BITS'(pos_sum >> sh);
      r.current_avg = tcsa_pkg::AVG_BITS'(cur_sum >> sh);
      r.voltage_avg = tcsa_pkg::AVG_BITS'(volt_sum >> sh);
      pos_sum = '0;
      cur_sum = '0;
      volt_sum = '0;
      avg_ready = 1'b0;
    end
    r.next_channel = sel;
    r.is_ready = avg_ready;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= 40) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  task automatic check_field(string name, logic [15:0] seen, logic [15:0] want);
    if (seen !== want) begin
      report_mismatch($sformatf("%s mismatch: got %0h want %0h", name, seen, want));
    end
  endtask

  always @(posedge clk) begin
    tcsa_pkg::res_t want;
    if (rst) begin
      shift_cfg = tcsa_pkg::RESET_SHIFT;
      sel = tcsa_pkg::CH_POSITION;
      pos_sum = '0;
      cur_sum = '0;
      volt_sum = '0;
      rounds = '0;
      avg_ready = 1'b0;
      scan_results_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (scan_results_due.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing due, next_channel %0h",
                                    next_channel));
        end else begin
          want = scan_results_due.pop_front();
          check_field("next_channel", 16'(next_channel), 16'(want.next_channel));
          check_field("got", 16'(got), 16'(want.got));
          check_field("position_avg", 16'(position_avg), 16'(want.position_avg));
          check_field("current_avg", 16'(current_avg), 16'(want.current_avg));
          check_field("voltage_avg", 16'(voltage_avg), 16'(want.voltage_avg));
          check_field("is_ready", 16'(is_ready), 16'(want.is_ready));
        end
      end
      if (cfg_write_en) begin
        shift_cfg = cfg_write_data;
      end
      if (in_valid && in_ready) begin
        scan_results_due.push_back(scan_step(tcsa_pkg::op_t'(operation), sample));
      end
    end
    due_count <= scan_results_due.size();
    fail_count <= err_count;
  end

endmodule

// File: sim/three_channel_scan_averager_unit_test.sv
`timescale 1ns / 100ps

module three_channel_scan_averager_unit_test;

  localparam int STALL_LIMIT = 1000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        operation;
  logic [11:0] sample;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  next_channel;
  logic        got;
  logic [11:0] position_avg;
  logic [11:0] current_avg;
  logic [11:0] voltage_avg;
  logic        is_ready;
  logic        cfg_write_en;
  logic [2:0]  cfg_write_data;

  int fail_count;
  int due_count;
  int tx_idle_pct;
  int rx_stall_pct;
  int beats_sent;
  int quiet_cycles;

  three_channel_scan_averager_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .next_channel  (next_channel),
    .got           (got),
    .position_avg  (position_avg),
    .current_avg   (current_avg),
    .voltage_avg   (voltage_avg),
    .is_ready      (is_ready),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  scan_averager_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .next_channel  (next_channel),
    .got           (got),
    .position_avg  (position_avg),
    .current_avg   (current_avg),
    .voltage_avg   (voltage_avg),
    .is_ready      (is_ready),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .fail_count    (fail_count),
    .due_count     (due_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // ends the run if no beat moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [11:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 12'h000;
      1: return 12'hFFF;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic send_item(tcsa_pkg::op_t op, logic [11:0] smp);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    sample <= smp;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // lets every result due come back before the block is touched
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_count != 0);
  endtask

  task automatic write_shift(logic [2:0] value);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // full scan blocks with random samples, a few stray beats between them
  task automatic run_scan_phase(int shift, int n_items);
    int stop_at;
    int rounds_needed;
    stop_at = beats_sent + n_items;
    rounds_needed = 1 << ((shift > int'(tcsa_pkg::MAX_SHIFT)) ?
                          int'(tcsa_pkg::MAX_SHIFT) : shift);
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        send_item(tcsa_pkg::op_t'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
      end else begin
        for (int i = 0; i < 3 * rounds_needed; i++) begin
          send_item(tcsa_pkg::OP_SAMPLE, rand_sample());
        end
        repeat ($urandom_range(0, 2)) send_item(tcsa_pkg::OP_SAMPLE, rand_sample());
        send_item(tcsa_pkg::OP_READ, 12'($urandom_range(0, 4095)));
      end
    end
  endtask

  initial begin
    int shift_order[8];
    shift_order = '{0, 4, 7, 1, 2, 5, 3, 6};
    rst = 1'b1;
    in_valid = 1'b0;
    operation = tcsa_pkg::OP_SAMPLE;
    sample = '0;
    out_ready = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    beats_sent = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // read before anything has been averaged
    send_item(tcsa_pkg::OP_READ, 12'hFFF);
    drain();
    write_shift(3'd0);
    send_item(tcsa_pkg::OP_SAMPLE, 12'hFFF);
    send_item(tcsa_pkg::OP_SAMPLE, 12'hFFF);
    send_item(tcsa_pkg::OP_SAMPLE, 12'hFFF);
    // ready is set, this one is dropped
    send_item(tcsa_pkg::OP_SAMPLE, 12'hABC);
    send_item(tcsa_pkg::OP_READ, 12'h000);
    send_item(tcsa_pkg::OP_READ, 12'h555);
    send_item(tcsa_pkg::OP_SAMPLE, 12'h000);
    send_item(tcsa_pkg::OP_SAMPLE, 12'h800);
    send_item(tcsa_pkg::OP_SAMPLE, 12'h001);
    send_item(tcsa_pkg::OP_READ, 12'hFFF);
    // one round at shift 1, then lower to 0 so the count is already past
    drain();
    write_shift(3'd1);
    send_item(tcsa_pkg::OP_SAMPLE, 12'd100);
    send_item(tcsa_pkg::OP_SAMPLE, 12'd200);
    send_item(tcsa_pkg::OP_SAMPLE, 12'd300);
    drain();
    write_shift(3'd0);
    send_item(tcsa_pkg::OP_SAMPLE, 12'd1);
    send_item(tcsa_pkg::OP_SAMPLE, 12'd2);
    send_item(tcsa_pkg::OP_SAMPLE, 12'd3);
    send_item(tcsa_pkg::OP_READ, 12'h000);

    for (int p = 0; p < 8; p++) begin
      drain();
      write_shift(3'(shift_order[p]));
      case (p % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 84;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 84;
        end
        default: begin
          tx_idle_pct = 23;
          rx_stall_pct = 23;
        end
      endcase
      run_scan_phase(shift_order[p], 48);
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tcsa_pkg.sv
rtl/tcsa_core.sv
rtl/three_channel_scan_averager_unit.sv
sim/scan_averager_checker.sv
sim/three_channel_scan_averager_unit_test.sv
